// File: src/lppi_pkg.sv
// shared constants, types and codes for the looped path playback interpolator
// no dependencies; imported by the channel interfaces and the top level

package lppi_pkg;

  localparam int MAX_POINTS   = 1024;
  localparam int COORD_BITS   = 12;
  localparam int TIME_BITS    = 24;

  localparam int ADDR_BITS    = $clog2(MAX_POINTS);
  localparam int CNT_BITS     = $clog2(MAX_POINTS + 1);
  localparam int DIV_W        = COORD_BITS + TIME_BITS;
  localparam int DIV_CNT_BITS = $clog2(DIV_W + 1);

  typedef enum logic [1:0] {
    KIND_START  = 2'd0,
    KIND_APPEND = 2'd1,
    KIND_STOP   = 2'd2,
    KIND_QUERY  = 2'd3
  } kind_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
    logic [TIME_BITS-1:0]  t;
  } point_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_TOTAL,
    S_CHECK,
    S_FOLD,
    S_SCAN,
    S_MUL,
    S_DIV,
    S_DONE
  } state_t;

endpackage

// File: src/lppi_in_if.sv
// input channel: valid/ready handshake carrying one command or query
// depends on lppi_pkg for field widths

interface lppi_in_if import lppi_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [1:0]            kind;
  logic [COORD_BITS-1:0] x;
  logic [COORD_BITS-1:0] y;
  logic [TIME_BITS-1:0]  time_ms;

  modport source (output valid, output kind, output x, output y, output time_ms,
                  input ready);
  modport sink   (input valid, input kind, input x, input y, input time_ms,
                  output ready);
endinterface

// File: src/lppi_out_if.sv
// result channel: valid/ready handshake carrying one interpolated position
// depends on lppi_pkg for field widths

interface lppi_out_if import lppi_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] pos_x;
  logic [COORD_BITS-1:0] pos_y;
  logic                  found;

  modport source (output valid, output pos_x, output pos_y, output found,
                  input ready);
  modport sink   (input valid, input pos_x, input pos_y, input found,
                  output ready);
endinterface

// File: src/looped_path_playback_interpolator.sv
// looped path playback interpolator: records timestamped points, plays them back in a loop
// start, append and stop leave the sequencer in idle, so the block stays ready for the next transaction
// a query's run is bounded by the single store read port scanning one point per cycle and
// by the shared 36-step divider
// result sits in an output register, so the next transaction is taken while it waits
// rst (synchronous) clears the point count, recording flag and control; the store is not cleared

module looped_path_playback_interpolator import lppi_pkg::*; (
  input logic        clk,
  input logic        rst,
  lppi_in_if.sink    items,
  lppi_out_if.source results
);

  // control state
  state_t                state;
  state_t                state_next;
  logic [CNT_BITS-1:0]   count;
  logic                  recording;

  // point store, one write port and one registered read port
  point_t                mem [MAX_POINTS];
  point_t                mem_q;
  logic [ADDR_BITS-1:0]  rd_addr;
  logic                  wr_en;
  logic [ADDR_BITS-1:0]  wr_addr;
  point_t                wr_data;
  logic [CNT_BITS-1:0]   cnt_m1;

  // query context
  logic [TIME_BITS-1:0]  q_time;
  logic [TIME_BITS-1:0]  r_time;
  logic [TIME_BITS-1:0]  total;
  logic                  q_empty;
  logic                  fold_needed;

  // segment scan
  logic [CNT_BITS-1:0]   scan_idx;
  logic                  issue;
  logic                  pv;
  logic                  have_prev;
  point_t                prev;
  logic                  seg_match;
  point_t                seg_a;
  point_t                seg_b;
  logic [TIME_BITS-1:0]  part;
  logic [TIME_BITS-1:0]  whole;
  logic                  hit;

  // shared multiply and restoring divider
  logic                  lane;
  logic [COORD_BITS-1:0] a_c;
  logic [COORD_BITS-1:0] b_c;
  logic                  neg;
  logic [COORD_BITS-1:0] mag;
  logic [DIV_W-1:0]      prod;
  logic [DIV_W-1:0]      dv_num;
  logic [TIME_BITS-1:0]  dv_rem;
  logic [TIME_BITS-1:0]  dv_den;
  logic [DIV_CNT_BITS-1:0] dv_cnt;
  logic                  div_busy;
  logic [TIME_BITS:0]    div_shift;
  logic [TIME_BITS:0]    div_diff;
  logic                  div_ge;
  logic [TIME_BITS-1:0]  rem_next;
  logic [COORD_BITS-1:0] quo;
  logic [COORD_BITS-1:0] lerp_val;
  logic [COORD_BITS-1:0] res_x;
  logic [COORD_BITS-1:0] res_y;

  // output register
  logic                  out_valid;
  logic [COORD_BITS-1:0] out_x;
  logic [COORD_BITS-1:0] out_y;
  logic                  out_found;
  logic                  out_free;
  logic                  in_acc;

  // handshakes
  assign items.ready     = (state == S_IDLE);
  assign in_acc          = items.valid && items.ready;
  assign out_free        = !out_valid || results.ready;
  assign results.valid   = out_valid;
  assign results.pos_x   = out_x;
  assign results.pos_y   = out_y;
  assign results.found   = out_found;

  // store writes: start always lands at entry 0 with time 0, append at the fill point
  assign wr_en   = in_acc && ((items.kind == KIND_START) ||
                   ((items.kind == KIND_APPEND) && (count < CNT_BITS'(MAX_POINTS))));
  assign wr_addr = (items.kind == KIND_START) ? '0 : count[ADDR_BITS-1:0];
  assign wr_data = '{x: items.x, y: items.y,
                     t: (items.kind == KIND_START) ? '0 : items.time_ms};
  assign cnt_m1  = count - CNT_BITS'(1);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    mem_q <= mem[rd_addr];
  end

  // loop length comes from the last stored point
  assign total       = mem_q.t;
  assign q_empty     = recording || (count < CNT_BITS'(2)) || (total == '0);
  assign fold_needed = (q_time > total);

  // scan issues one read per cycle; the data comes back in the cycle after the read is issued
  assign issue     = (scan_idx < count);
  assign seg_match = pv && have_prev && (r_time >= prev.t) && (r_time < mem_q.t);

  // lerp operands for the current lane (x first, then y)
  assign a_c  = lane ? seg_a.y : seg_a.x;
  assign b_c  = lane ? seg_b.y : seg_b.x;
  assign neg  = (b_c < a_c);
  assign mag  = neg ? (a_c - b_c) : (b_c - a_c);
  assign prod = {{TIME_BITS{1'b0}}, mag} * {{COORD_BITS{1'b0}}, part};

  // one restoring division step per cycle
  assign div_busy  = (dv_cnt != '0);
  assign div_shift = {dv_rem, dv_num[DIV_W-1]};
  assign div_ge    = (div_shift >= {1'b0, dv_den});
  assign div_diff  = div_shift - {1'b0, dv_den};
  assign rem_next  = div_ge ? div_diff[TIME_BITS-1:0] : div_shift[TIME_BITS-1:0];

  // part < whole, so the quotient stays below the coordinate span
  assign quo      = dv_num[COORD_BITS-1:0];
  assign lerp_val = neg ? (a_c - quo) : (a_c + quo);

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    rd_addr    = scan_idx[ADDR_BITS-1:0];
    case (state)
      S_IDLE: begin
        if (in_acc && (items.kind == KIND_QUERY)) begin
          state_next = S_TOTAL;
        end
      end
      S_TOTAL: begin
        rd_addr    = cnt_m1[ADDR_BITS-1:0];
        state_next = S_CHECK;
      end
      S_CHECK: begin
        if (q_empty) begin
          state_next = S_DONE;
        end else if (fold_needed) begin
          state_next = S_FOLD;
        end else begin
          state_next = S_SCAN;
        end
      end
      S_FOLD: begin
        if (!div_busy) begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (!issue && !pv) begin
          state_next = hit ? S_MUL : S_DONE;
        end
      end
      S_MUL: begin
        state_next = S_DIV;
      end
      S_DIV: begin
        if (!div_busy) begin
          state_next = lane ? S_DONE : S_MUL;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      recording <= 1'b0;
      out_valid <= 1'b0;
      dv_cnt    <= '0;
      pv        <= 1'b0;
    end else begin
      if (in_acc) begin
        case (items.kind)
          KIND_START: begin
            recording <= 1'b1;
            count     <= CNT_BITS'(1);
          end
          KIND_APPEND: begin
            // full store drops the point
            if (count < CNT_BITS'(MAX_POINTS)) begin
              count <= count + CNT_BITS'(1);
            end
          end
          KIND_STOP: begin
            recording <= 1'b0;
          end
          default: begin
          end
        endcase
      end

      pv <= (state == S_SCAN) && issue;

      if (((state == S_CHECK) && !q_empty && fold_needed) || (state == S_MUL)) begin
        dv_cnt <= DIV_CNT_BITS'(DIV_W);
      end else if (div_busy) begin
        dv_cnt <= dv_cnt - DIV_CNT_BITS'(1);
      end

      if ((state == S_DONE) && out_free) begin
        out_valid <= 1'b1;
      end else if (results.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      q_time <= items.time_ms;
    end
    case (state)
      S_CHECK: begin
        r_time    <= q_time;
        hit       <= 1'b0;
        res_x     <= '0;
        res_y     <= '0;
        scan_idx  <= '0;
        have_prev <= 1'b0;
        lane      <= 1'b0;
        // fold to ((t - 1) mod T) + 1
        dv_num    <= {{COORD_BITS{1'b0}}, q_time - TIME_BITS'(1)};
        dv_rem    <= '0;
        dv_den    <= total;
      end
      S_FOLD: begin
        if (div_busy) begin
          dv_num <= {dv_num[DIV_W-2:0], div_ge};
          dv_rem <= rem_next;
        end else begin
          r_time <= dv_rem + TIME_BITS'(1);
        end
      end
      S_SCAN: begin
        if (issue) begin
          scan_idx <= scan_idx + CNT_BITS'(1);
        end
        if (pv) begin
          // later segments overwrite earlier matches
          if (seg_match) begin
            seg_a <= prev;
            seg_b <= mem_q;
            part  <= r_time - prev.t;
            whole <= mem_q.t - prev.t;
            hit   <= 1'b1;
          end
          prev      <= mem_q;
          have_prev <= 1'b1;
        end
      end
      S_MUL: begin
        dv_num <= prod;
        dv_rem <= '0;
        dv_den <= whole;
      end
      S_DIV: begin
        if (div_busy) begin
          dv_num <= {dv_num[DIV_W-2:0], div_ge};
          dv_rem <= rem_next;
        end else begin
          if (lane) begin
            res_y <= lerp_val;
          end else begin
            res_x <= lerp_val;
          end
          lane <= 1'b1;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_x     <= res_x;
          out_y     <= res_y;
          out_found <= hit;
        end
      end
      default: begin
      end
    endcase
  end

  // a query always moves the sequencer off idle into the total read
  assert property (@(posedge clk) disable iff (rst)
    (in_acc && (items.kind == KIND_QUERY)) |=> (state == S_TOTAL))
    else $error("query transaction did not start the sequencer");

  // commands never produce a result transaction
  assert property (@(posedge clk) disable iff (rst)
    (in_acc && (items.kind != KIND_QUERY) && !out_valid) |=> !out_valid)
    else $error("command produced a result");

  // no match means a zero position
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_found) |-> ((out_x == '0) && (out_y == '0)))
    else $error("position not zero without a match");

  // the fill count never passes the store depth
  assert property (@(posedge clk) disable iff (rst)
    (count <= CNT_BITS'(MAX_POINTS)))
    else $error("point count beyond store depth");

  // the divider only runs in its two sequencer steps
  assert property (@(posedge clk) disable iff (rst)
    div_busy |-> ((state == S_FOLD) || (state == S_DIV)))
    else $error("divider running outside fold or lerp");

endmodule

// File: tb/tb_looped_path_playback_interpolator.sv
`timescale 1ns / 1ps
// self-checking testbench for the looped path playback interpolator: records paths, plays
// them back with queries and checks each position transaction against an in-bench predictor
// depends on lppi_pkg, lppi_in_if, lppi_out_if and looped_path_playback_interpolator

module tb_looped_path_playback_interpolator;
  import lppi_pkg::*;

  localparam int TIME_MAX      = (1 << TIME_BITS) - 1;
  localparam int COORD_MAX     = (1 << COORD_BITS) - 1;
  localparam int RANDOM_ITEMS  = 510;
  // receiver hold-off, long enough for two queries to back up inside the block
  localparam int HOLD_CYCLES   = 2500;
  // long enough for a full-store query, so this covers any straggler
  localparam int SETTLE_CYCLES = 1300;
  // slowest correct run is well under this: the longest queries plus every stall
  localparam int CYCLE_LIMIT   = 2000000;

  typedef struct packed {
    logic [COORD_BITS-1:0] pos_x;
    logic [COORD_BITS-1:0] pos_y;
    logic                  found;
  } position_t;

  // how the next append time moves along a recorded path
  typedef enum {STEP_FINE, STEP_MEDIUM, STEP_COARSE, STEP_SPAN} step_mode_t;

  // where a playback query lands relative to the recorded path
  typedef enum {
    Q_ZERO, Q_END, Q_PAST_END, Q_IN_SPAN, Q_ON_POINT, Q_NEAR_POINT, Q_WRAPPED, Q_ANY
  } query_spot_t;

  // shadow copy of the point store plus the queue of positions still owed by the block
  class position_book;
    bit [COORD_BITS-1:0] px [MAX_POINTS];
    bit [COORD_BITS-1:0] py [MAX_POINTS];
    bit [TIME_BITS-1:0]  pt [MAX_POINTS];
    int                  count;
    bit                  recording;
    position_t           expected_positions [$];
    int                  mismatches;
    int                  checked;
    int                  hits;
    int                  stored;

    function new();
      count      = 0;
      recording  = 0;
      mismatches = 0;
      checked    = 0;
      hits       = 0;
      stored     = 0;
    endfunction

    function int pending();
      return expected_positions.size();
    endfunction

    // a + trunc((b - a) * part / whole) with the sign handled on the magnitude
    function bit [COORD_BITS-1:0] blend(bit [COORD_BITS-1:0] a, b,
                                        bit [TIME_BITS-1:0] part, whole);
      longint unsigned mag;
      if (b >= a) begin
        mag = b - a;
        mag = (mag * part) / whole;
        return a + mag[COORD_BITS-1:0];
      end
      mag = a - b;
      mag = (mag * part) / whole;
      return a - mag[COORD_BITS-1:0];
    endfunction

    // fold a query time past T into (0,T] and interpolate on the last matching segment
    function position_t locate(bit [TIME_BITS-1:0] tq);
      position_t          p;
      bit [TIME_BITS-1:0] total;
      bit [TIME_BITS-1:0] r;
      p = '0;
      if (!recording && count >= 2) begin
        total = pt[count-1];
        if (total != 0) begin
          r = tq;
          if (r > total) r = ((r - 1) % total) + 1;
          for (int i = 0; i + 1 < count; i++) begin
            if (r >= pt[i] && r < pt[i+1]) begin
              p.pos_x = blend(px[i], px[i+1], r - pt[i], pt[i+1] - pt[i]);
              p.pos_y = blend(py[i], py[i+1], r - pt[i], pt[i+1] - pt[i]);
              p.found = 1'b1;
            end
          end
        end
      end
      return p;
    endfunction

    function void note_transaction(kind_t k, bit [COORD_BITS-1:0] cx, cy,
                                   bit [TIME_BITS-1:0] tm);
      case (k)
        KIND_START: begin
          recording = 1'b1;
          px[0]     = cx;
          py[0]     = cy;
          pt[0]     = '0;
          count     = 1;
          stored++;
        end
        KIND_APPEND: begin
          if (count < MAX_POINTS) begin
            px[count] = cx;
            py[count] = cy;
            pt[count] = tm;
            count++;
            stored++;
          end
        end
        KIND_STOP: begin
          recording = 1'b0;
        end
        KIND_QUERY: begin
          expected_positions.insert(expected_positions.size(), locate(tm));
        end
        default: begin
        end
      endcase
    endfunction

    function void check_position(position_t got);
      position_t want;
      checked++;
      if (expected_positions.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("position with no query waiting: x=%0d y=%0d found=%0d",
                   got.pos_x, got.pos_y, got.found);
        return;
      end
      want = expected_positions.pop_front();
      if (want.found) hits++;
      if (got.pos_x !== want.pos_x || got.pos_y !== want.pos_y || got.found !== want.found) begin
        mismatches++;
        if (mismatches <= 10)
          $display("position mismatch: expected x=%0d y=%0d found=%0d, got x=%0d y=%0d found=%0d",
                   want.pos_x, want.pos_y, want.found, got.pos_x, got.pos_y, got.found);
      end
    endfunction
  endclass

  logic clk;
  logic rst;

  lppi_in_if  items_ch ();
  lppi_out_if results_ch ();

  looped_path_playback_interpolator dut (
    .clk     (clk),
    .rst     (rst),
    .items   (items_ch),
    .results (results_ch)
  );

  position_book       book;
  int                 items_sent;
  int                 cycles;
  int                 stall_asks;  // bumped by the stimulus, served by the receiver
  bit                 calm;        // no idling on either side while set
  bit [TIME_BITS-1:0] path_times [$];

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // extreme coordinates show up often so both lerp directions hit full swing
  function automatic bit [COORD_BITS-1:0] pick_coord();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return COORD_MAX;
      default: return COORD_BITS'($urandom);
    endcase
  endfunction

  // query time around the most recent path: edges, points, inside, wrapped or anywhere
  function automatic bit [TIME_BITS-1:0] pick_query_time();
    longint      total;
    longint      q;
    query_spot_t spot;
    total = path_times.size() ? path_times[path_times.size()-1] : 0;
    spot  = query_spot_t'($urandom_range(0, 7));
    case (spot)
      Q_ZERO:       q = 0;
      Q_END:        q = total;
      Q_PAST_END:   q = total + 1;
      Q_IN_SPAN:    q = $urandom_range(0, total);
      Q_ON_POINT:   q = path_times[$urandom_range(0, path_times.size() - 1)];
      Q_NEAR_POINT: q = longint'(path_times[$urandom_range(0, path_times.size() - 1)])
                        + $urandom_range(0, 2) - 1;
      Q_WRAPPED:    q = total * $urandom_range(1, 50) + $urandom_range(0, total);
      default:      q = $urandom & TIME_MAX;
    endcase
    if (q < 0) q = 0;
    if (q > TIME_MAX) q = TIME_MAX;
    return q[TIME_BITS-1:0];
  endfunction

  // offer one transaction, idling first at random, and log it once it is taken
  task automatic push_item(kind_t k, bit [COORD_BITS-1:0] cx, cy, bit [TIME_BITS-1:0] tm);
    while (!calm && $urandom_range(0, 99) < 33) begin
      items_ch.valid <= 1'b0;
      @(negedge clk);
    end
    items_ch.valid   <= 1'b1;
    items_ch.kind    <= k;
    items_ch.x       <= cx;
    items_ch.y       <= cy;
    items_ch.time_ms <= tm;
    @(posedge clk);
    while (!items_ch.ready) @(posedge clk);
    book.note_transaction(k, cx, cy, tm);
    items_sent++;
    @(negedge clk);
  endtask

  // sender goes quiet until every owed position has come back
  task automatic wait_drained();
    items_ch.valid <= 1'b0;
    do @(negedge clk); while (book.pending() != 0);
  endtask

  // start plus n-1 appends, mostly with rising times, now and then an out-of-order one, then a stop if close
  task automatic record_path(int n, bit close);
    bit [TIME_BITS:0] tacc;
    int unsigned      inc;
    step_mode_t       mode;
    mode = step_mode_t'($urandom_range(0, 3));
    tacc = '0;
    path_times.delete();
    path_times.insert(path_times.size(), TIME_BITS'(0));
    push_item(KIND_START, pick_coord(), pick_coord(), TIME_BITS'($urandom));
    for (int i = 1; i < n; i++) begin
      case (mode)
        STEP_FINE:   inc = $urandom_range(1, 40);
        STEP_MEDIUM: inc = $urandom_range(1, 5000);
        STEP_COARSE: inc = $urandom_range(1, 1 << 20);
        default:     inc = $urandom_range(1, TIME_MAX / n);
      endcase
      if ($urandom_range(0, 15) == 0) tacc = {1'b0, TIME_BITS'($urandom)};
      else                            tacc = tacc + (TIME_BITS + 1)'(inc);
      if (tacc > TIME_MAX) tacc = TIME_MAX;
      push_item(KIND_APPEND, pick_coord(), pick_coord(), tacc[TIME_BITS-1:0]);
      path_times.insert(path_times.size(), tacc[TIME_BITS-1:0]);
    end
    if (close) push_item(KIND_STOP, COORD_BITS'($urandom), COORD_BITS'($urandom),
                         TIME_BITS'($urandom));
  endtask

  // receiver: random back-pressure, plus one long hold-off when the stimulus asks
  initial begin : receiver
    int hold_left;
    int stall_taken;
    hold_left        = 0;
    stall_taken      = 0;
    results_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_taken != stall_asks) begin
        stall_taken = stall_asks;
        hold_left   = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        results_ch.ready <= 1'b0;
      end else begin
        results_ch.ready <= calm || ($urandom_range(0, 99) >= 33);
      end
    end
  end

  // every accepted result transaction goes straight to the checker
  initial begin : monitor
    position_t got;
    forever begin
      @(posedge clk);
      if (!rst && results_ch.valid && results_ch.ready) begin
        got.pos_x = results_ch.pos_x;
        got.pos_y = results_ch.pos_y;
        got.found = results_ch.found;
        book.check_position(got);
      end
    end
  end

  // watchdog on total run length
  initial begin : watchdog
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("tb_looped_path_playback_interpolator NOT OK");
    $finish;
  end

  initial begin : stimulus
    int target;
    int round;
    int n;

    book             = new();
    rst              = 1'b1;
    calm             = 1'b0;
    stall_asks       = 0;
    items_sent       = 0;
    items_ch.valid   = 1'b0;
    items_ch.kind    = KIND_START;
    items_ch.x       = '0;
    items_ch.y       = '0;
    items_ch.time_ms = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: empty store, then appends before any start
    push_item(KIND_QUERY,  '0, '0, 7);
    push_item(KIND_APPEND, COORD_MAX, '0, TIME_MAX);
    push_item(KIND_APPEND, '0, COORD_MAX, 0);
    // two points but the last time is zero
    push_item(KIND_QUERY,  '0, '0, 5);
    // falling coordinates over one segment, first queried while still recording
    push_item(KIND_START,  COORD_MAX, COORD_MAX, TIME_MAX);
    push_item(KIND_APPEND, '0, '0, 100);
    push_item(KIND_QUERY,  '0, '0, 50);
    push_item(KIND_STOP,   '0, '0, '0);
    push_item(KIND_QUERY,  '0, '0, 0);
    push_item(KIND_QUERY,  '0, '0, 50);
    push_item(KIND_QUERY,  '0, '0, 100);
    push_item(KIND_QUERY,  '0, '0, 150);
    push_item(KIND_QUERY,  COORD_MAX, COORD_MAX, TIME_MAX);
    // append after stop still lands in the store
    push_item(KIND_APPEND, COORD_MAX, COORD_MAX, 200);
    push_item(KIND_QUERY,  '0, '0, 150);
    // repeated time, then a falling time: overlapping segments, last match wins
    push_item(KIND_APPEND, '0, '0, 200);
    push_item(KIND_QUERY,  '0, '0, 199);
    push_item(KIND_APPEND, 2048, 1, 50);
    push_item(KIND_APPEND, '0, COORD_MAX, 150);
    push_item(KIND_QUERY,  '0, '0, 120);
    // a lone point after stop
    push_item(KIND_START,  1, 2, '0);
    push_item(KIND_STOP,   '0, '0, '0);
    push_item(KIND_QUERY,  '0, '0, 0);
    // closed path whose last time is zero
    push_item(KIND_START,  10, 20, '0);
    push_item(KIND_APPEND, 30, 40, 0);
    push_item(KIND_STOP,   '0, '0, '0);
    push_item(KIND_QUERY,  '0, '0, 0);

    // random: mostly well-formed record, stop, play sequences with some noise between
    target = items_sent + RANDOM_ITEMS;
    round  = 0;
    while (items_sent < target) begin
      round++;
      calm = (round >= 30 && round < 45);
      if (round == 20) begin
        // back up the block with queries against a held receiver, then let it drain
        record_path(4, 1'b1);
        stall_asks++;
        repeat (8) push_item(KIND_QUERY, COORD_BITS'($urandom), COORD_BITS'($urandom),
                             pick_query_time());
        wait_drained();
      end else if ($urandom_range(0, 99) < 80) begin
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(11, 40) : $urandom_range(2, 10);
        // an unclosed path now and then leaves queries hitting an active recording
        record_path(n, $urandom_range(0, 9) != 0);
        repeat ($urandom_range(2, 6))
          push_item(KIND_QUERY, COORD_BITS'($urandom), COORD_BITS'($urandom),
                    pick_query_time());
        if ($urandom_range(0, 24) == 0) wait_drained();
      end else begin
        push_item(kind_t'($urandom_range(0, 3)), COORD_BITS'($urandom),
                  COORD_BITS'($urandom), TIME_BITS'($urandom));
      end
    end
    calm = 1'b0;

    // drain, then give any stray result time to show up
    wait_drained();
    repeat (SETTLE_CYCLES) @(negedge clk);

    $display("run covered %0d transactions in and %0d positions out, %0d on a segment",
             items_sent, book.checked, book.hits);
    $display("%0d points recorded over %0d cycles", book.stored, cycles);
    if (book.mismatches == 0 && book.pending() == 0) begin
      $display("tb_looped_path_playback_interpolator OK");
    end else begin
      $display("tb_looped_path_playback_interpolator NOT OK");
    end
    $finish;
  end

endmodule
